// ===== hdl/ngtsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ngtsc_pkg
// Types and constants shared by the n-gram table size counter: request and
// result payloads, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ngtsc_pkg;

	localparam int ID_W          = 16;
	localparam int CNT_W         = 32;
	localparam int SIZE_W        = 32;
	localparam int ORDER_CFG_W   = 3;
	localparam int CFG_DATA_W    = 32;
	localparam int NUM_IN_IDS    = 4;
	localparam int NUM_CUTS      = 3;
	localparam int NUM_OUT_SIZES = 3;

	localparam logic [SIZE_W-1:0]      FUDGE       = SIZE_W'(10);
	localparam logic [ORDER_CFG_W-1:0] ORDER_RESET = ORDER_CFG_W'(3);

	typedef enum logic [1:0] {
		REG_ORDER        = 2'd0,
		REG_CUT_BIGRAM   = 2'd1,
		REG_CUT_TRIGRAM  = 2'd2,
		REG_CUT_FOURGRAM = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [ID_W-1:0]  word_id_0;
		logic [ID_W-1:0]  word_id_1;
		logic [ID_W-1:0]  word_id_2;
		logic [ID_W-1:0]  word_id_3;
		logic [CNT_W-1:0] gram_count;
		logic             last_gram;
	} in_item_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size_bigram;
		logic [SIZE_W-1:0] size_trigram;
		logic [SIZE_W-1:0] size_fourgram;
		logic              overflow;
	} out_item_t;

endpackage

// ===== hdl/ngram_table_size_counter.sv =====
// ----------------------------------------------------------------------------
// ngram_table_size_counter
// Counts n-gram table sizes over a sorted stream of word-id n-grams with
// counts. One request is accepted every cycle unless a last request is held
// in the input register; each passes an input register and one state-update
// stage, so a result is registered as the last n-gram's request leaves the
// input register. The loop through the per-level compare, accumulate and
// size update sets this rate. A last request waits in the input register
// only while the previous result is unaccepted. A request marked last
// flushes all open groups, emits the bigram, trigram and fourgram sizes
// (each plus 10, 0 for levels beyond the order) and clears the stream state;
// the configuration registers keep their values. Counts and sizes saturate
// and raise overflow. Configuration writes are taken only while the input
// register is empty.
`timescale 1ns / 1ps

module ngram_table_size_counter #(
	parameter int MAX_ORDER  = 4,
	parameter int ID_BITS    = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  ngtsc_pkg::cfg_reg_t                cfg_index,
	input  logic [ngtsc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ngtsc_pkg::in_item_t                in_item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output ngtsc_pkg::out_item_t               out_item
);

	import ngtsc_pkg::*;

	logic [ORDER_CFG_W-1:0] order_q;
	logic [SIZE_W-1:0]      cutoff_q [NUM_CUTS];

	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;

	logic [ID_BITS-1:0]    prev_ids_q [MAX_ORDER];
	logic [COUNT_BITS-1:0] accum_q    [MAX_ORDER];
	logic [SIZE_W-1:0]     sizes_q    [MAX_ORDER-1];
	logic                  seen_first_q;
	logic                  saturated_q;

	logic [ID_BITS-1:0]    nxt_ids    [MAX_ORDER];
	logic [COUNT_BITS-1:0] nxt_accum  [MAX_ORDER];
	logic [SIZE_W-1:0]     nxt_sizes  [MAX_ORDER-1];
	logic                  nxt_saturated;
	out_item_t             result;

	logic      out_valid_q;
	out_item_t out_item_q;

	assign cfg_ready = !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q  <= ORDER_RESET;
			cutoff_q <= '{default: '0};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORDER:        order_q     <= cfg_data[ORDER_CFG_W-1:0];
				REG_CUT_BIGRAM:   cutoff_q[0] <= cfg_data[SIZE_W-1:0];
				REG_CUT_TRIGRAM:  cutoff_q[1] <= cfg_data[SIZE_W-1:0];
				REG_CUT_FOURGRAM: cutoff_q[2] <= cfg_data[SIZE_W-1:0];
				default:          order_q     <= order_q;
			endcase
		end
	end

	// a non-last request never waits on the output side
	assign advance  = valid_s1 && (!item_s1.last_gram || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	ngtsc_update #(
		.MAX_ORDER  (MAX_ORDER),
		.ID_BITS    (ID_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_update (
		.item          (item_s1),
		.order         (order_q),
		.cutoffs       (cutoff_q),
		.prev_ids      (prev_ids_q),
		.accum         (accum_q),
		.sizes         (sizes_q),
		.seen_first    (seen_first_q),
		.saturated     (saturated_q),
		.nxt_ids       (nxt_ids),
		.nxt_accum     (nxt_accum),
		.nxt_sizes     (nxt_sizes),
		.nxt_saturated (nxt_saturated),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ids_q   <= '{default: '0};
			accum_q      <= '{default: '0};
			sizes_q      <= '{default: '0};
			seen_first_q <= 1'b0;
			saturated_q  <= 1'b0;
		end else if (advance) begin
			if (item_s1.last_gram) begin
				prev_ids_q   <= '{default: '0};
				accum_q      <= '{default: '0};
				sizes_q      <= '{default: '0};
				seen_first_q <= 1'b0;
				saturated_q  <= 1'b0;
			end else begin
				prev_ids_q   <= nxt_ids;
				accum_q      <= nxt_accum;
				sizes_q      <= nxt_sizes;
				seen_first_q <= 1'b1;
				saturated_q  <= nxt_saturated;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.last_gram) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_gram) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	// a result only comes from a last request leaving the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && item_s1.last_gram))
		else $error("result without a last request");

	// the stream state is back at reset after a result is formed
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.last_gram) |=> (!seen_first_q && !saturated_q))
		else $error("stream state not cleared after last request");

	// a held request stays in the input register unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled request lost or changed");
`endif

endmodule

// ===== hdl/ngtsc_update.sv =====
// ----------------------------------------------------------------------------
// ngtsc_update
// Next-state logic for one n-gram: finds the first differing id position,
// accumulates or restarts each level, counts closed groups against their
// cutoffs, and on the last n-gram flushes and forms the size result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ngtsc_update #(
	parameter int MAX_ORDER  = 4,
	parameter int ID_BITS    = 16,
	parameter int COUNT_BITS = 32
) (
	input  ngtsc_pkg::in_item_t                item,
	input  logic [ngtsc_pkg::ORDER_CFG_W-1:0]  order,
	input  logic [ngtsc_pkg::SIZE_W-1:0]       cutoffs   [ngtsc_pkg::NUM_CUTS],
	input  logic [ID_BITS-1:0]                 prev_ids  [MAX_ORDER],
	input  logic [COUNT_BITS-1:0]              accum     [MAX_ORDER],
	input  logic [ngtsc_pkg::SIZE_W-1:0]       sizes     [MAX_ORDER-1],
	input  logic                               seen_first,
	input  logic                               saturated,
	output logic [ID_BITS-1:0]                 nxt_ids   [MAX_ORDER],
	output logic [COUNT_BITS-1:0]              nxt_accum [MAX_ORDER],
	output logic [ngtsc_pkg::SIZE_W-1:0]       nxt_sizes [MAX_ORDER-1],
	output logic                               nxt_saturated,
	output ngtsc_pkg::out_item_t               result
);

	import ngtsc_pkg::*;

	localparam int LVL_W = $clog2(MAX_ORDER + 1);
	localparam int CMP_W = (COUNT_BITS > SIZE_W) ? COUNT_BITS : SIZE_W;
	localparam logic [SIZE_W-1:0]     SIZE_MAX  = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [LVL_W-1:0]      n_lvl;
	logic [LVL_W-1:0]      diff;
	logic [ID_W-1:0]       word_ids [NUM_IN_IDS];
	logic [ID_BITS-1:0]    ids      [MAX_ORDER];
	logic [SIZE_W-1:0]     cut_lvl  [MAX_ORDER];
	logic [COUNT_BITS-1:0] count;
	logic [COUNT_BITS:0]   acc_sum  [MAX_ORDER];
	logic [MAX_ORDER-1:0]  close_hit;
	logic [MAX_ORDER-1:0]  flush_hit;
	logic                  sat_main;
	logic                  sat_res;
	logic [SIZE_W-1:0]     sz_pad   [NUM_OUT_SIZES];
	logic [SIZE_W:0]       fudge_sum [NUM_OUT_SIZES];
	logic [SIZE_W-1:0]     sz_out   [NUM_OUT_SIZES];

	assign word_ids = '{item.word_id_0, item.word_id_1, item.word_id_2, item.word_id_3};
	assign count    = COUNT_BITS'(item.gram_count);

	// positions past the input fields read as id 0, levels past the registers cut at 0
	for (genvar l = 0; l < MAX_ORDER; l++) begin : g_lvl
		if (l < NUM_IN_IDS) begin : g_id
			assign ids[l] = ID_BITS'(word_ids[l]);
		end else begin : g_id_zero
			assign ids[l] = '0;
		end
		if (l >= 1 && l <= NUM_CUTS) begin : g_cut
			assign cut_lvl[l] = cutoffs[l-1];
		end else begin : g_cut_zero
			assign cut_lvl[l] = '0;
		end
	end

	for (genvar k = 0; k < NUM_OUT_SIZES; k++) begin : g_pad
		if (k < MAX_ORDER - 1) begin : g_have
			assign sz_pad[k] = nxt_sizes[k];
		end else begin : g_none
			assign sz_pad[k] = '0;
		end
	end

	always_comb begin
		if (order == '0) begin
			n_lvl = LVL_W'(1);
		end else if (int'(order) > MAX_ORDER) begin
			n_lvl = LVL_W'(MAX_ORDER);
		end else begin
			n_lvl = LVL_W'(order);
		end
	end

	// first differing position, scanned from the top so the lowest wins
	always_comb begin
		diff = n_lvl;
		for (int i = MAX_ORDER - 1; i >= 0; i--) begin
			if (i < int'(n_lvl) && ids[i] != prev_ids[i]) begin
				diff = LVL_W'(i);
			end
		end
		if (!seen_first) begin
			diff = '0;
		end
	end

	always_comb begin
		sat_main  = saturated;
		nxt_ids   = prev_ids;
		nxt_accum = accum;
		nxt_sizes = sizes;
		close_hit = '0;
		flush_hit = '0;
		for (int i = 0; i < MAX_ORDER; i++) begin
			acc_sum[i] = {1'b0, accum[i]} + {1'b0, count};
			if (i < int'(n_lvl)) begin
				nxt_ids[i] = ids[i];
				if (i < int'(diff)) begin
					if (acc_sum[i][COUNT_BITS]) begin
						sat_main     = 1'b1;
						nxt_accum[i] = COUNT_MAX;
					end else begin
						nxt_accum[i] = acc_sum[i][COUNT_BITS-1:0];
					end
				end else begin
					close_hit[i] = (i > 0) && (CMP_W'(accum[i]) > CMP_W'(cut_lvl[i]));
					nxt_accum[i] = count;
				end
			end
		end
		// final flush closes every open group above level 0 after the update
		for (int i = 1; i < MAX_ORDER; i++) begin
			flush_hit[i] = item.last_gram && (i < int'(n_lvl)) &&
			               (CMP_W'(nxt_accum[i]) > CMP_W'(cut_lvl[i]));
		end
		for (int j = 0; j < MAX_ORDER - 1; j++) begin
			if (close_hit[j+1]) begin
				if (nxt_sizes[j] == SIZE_MAX) begin
					sat_main = 1'b1;
				end else begin
					nxt_sizes[j] = nxt_sizes[j] + SIZE_W'(1);
				end
			end
			if (flush_hit[j+1]) begin
				if (nxt_sizes[j] == SIZE_MAX) begin
					sat_main = 1'b1;
				end else begin
					nxt_sizes[j] = nxt_sizes[j] + SIZE_W'(1);
				end
			end
		end
	end

	// levels not in use report 0 without the fudge
	always_comb begin
		sat_res = sat_main;
		for (int k = 0; k < NUM_OUT_SIZES; k++) begin
			fudge_sum[k] = {1'b0, sz_pad[k]} + {1'b0, FUDGE};
			sz_out[k]    = '0;
			if (k + 1 < int'(n_lvl)) begin
				if (fudge_sum[k][SIZE_W]) begin
					sat_res   = 1'b1;
					sz_out[k] = SIZE_MAX;
				end else begin
					sz_out[k] = fudge_sum[k][SIZE_W-1:0];
				end
			end
		end
	end

	assign nxt_saturated        = sat_main;
	assign result.size_bigram   = sz_out[0];
	assign result.size_trigram  = sz_out[1];
	assign result.size_fourgram = sz_out[2];
	assign result.overflow      = sat_res;

endmodule
